// ----- hw/rtl/nos_pkg.sv -----
// ----------------------------------------------------------------------------
// nos_pkg: shared types and constants for the note-off scheduler
// command codes and the event word layout
// ----------------------------------------------------------------------------
`default_nettype none

package nos_pkg;

	localparam logic [2:0] CMD_NOTE_ON   = 3'd0;
	localparam logic [2:0] CMD_TICK      = 3'd1;
	localparam logic [2:0] CMD_MUTE      = 3'd2;
	localparam logic [2:0] CMD_SET_VEL   = 3'd3;
	localparam logic [2:0] CMD_SET_DUR   = 3'd4;
	localparam logic [2:0] CMD_SET_LINK  = 3'd5;
	localparam logic [2:0] CMD_CLEAR_TAB = 3'd6;

	localparam logic CFG_DEF_VEL = 1'b0;
	localparam logic CFG_DEF_DUR = 1'b1;

	localparam logic [6:0]  VEL_MAX       = 7'd127;
	localparam logic [6:0]  DEF_VEL_RESET = 7'd64;
	localparam logic [15:0] DEF_DUR_RESET = 16'd1000;

	// one event word to the output stage
	typedef struct packed {
		logic [6:0] note;
		logic [6:0] velocity;
		logic       last;
	} event_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nos_ram.sv -----
// ----------------------------------------------------------------------------
// nos_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module nos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/note_off_scheduler.sv -----
// ----------------------------------------------------------------------------
// note_off_scheduler: percussion note player with a time-sorted note-off queue
// resolves velocity and duration, purges linked and repeated notes, inserts
// the note end time into a sorted ring queue, pops the expired head on tick
// ----------------------------------------------------------------------------
//
// channel | dir | handshake           | words
// s_axis  | in  | tvalid/tready       | one command word
// m_axis  | out | tvalid/tready/tlast | zero to four event words per command
// cfg     | in  | we                  | default velocity, default duration
//
// a command runs table lookups plus up to two queue scans (purge of linked
// and own note) and a sorted insert that shifts entries one at a time
// through the single ram port, each shift a read state (ST_MRD) then a write
// state (ST_MWR). the single-port queue and table rams set the command time.
// after reset a clearing pass over max(QUEUE_DEPTH, NOTE_COUNT) addresses
// zeroes tables and queue note and time; s_axis_tready stays low meanwhile.
// clear_tables repeats the NOTE_COUNT table sweep.
// each event word waits in the output register; the sequencer stalls there
// until m_axis_tready takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module note_off_scheduler
	import nos_pkg::*;
#(
	parameter int QUEUE_DEPTH = 128,
	parameter int NOTE_COUNT  = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// cmd[2:0] note[9:3] velocity[16:10] duration[32:17] now[64:33]
	// table_value[80:65], zero fill to 88
	input  wire  [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// out_note[6:0] out_velocity[13:7], zero fill to 16
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(NOTE_COUNT);
	localparam int CW = (QW > NW) ? QW + 1 : NW + 1;
	localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);

	// sequencer states
	localparam logic [4:0] ST_CLEAR  = 5'd0;
	localparam logic [4:0] ST_IDLE   = 5'd1;
	localparam logic [4:0] ST_TRD    = 5'd2;  // table read issued
	localparam logic [4:0] ST_TGET   = 5'd3;  // table data back
	localparam logic [4:0] ST_PRD    = 5'd4;  // purge: read entry
	localparam logic [4:0] ST_PCHK   = 5'd5;  // purge: check entry
	localparam logic [4:0] ST_ON     = 5'd6;  // emit note-on
	localparam logic [4:0] ST_FULL   = 5'd7;  // forced pop read
	localparam logic [4:0] ST_FCHK   = 5'd8;
	localparam logic [4:0] ST_SRD    = 5'd9;  // insert search read
	localparam logic [4:0] ST_SCHK   = 5'd10;
	localparam logic [4:0] ST_MRD    = 5'd11; // shift: read prev
	localparam logic [4:0] ST_MWR    = 5'd12; // shift: write cur
	localparam logic [4:0] ST_PUT    = 5'd13;
	localparam logic [4:0] ST_TKRD   = 5'd14;
	localparam logic [4:0] ST_TKCHK  = 5'd15;
	localparam logic [4:0] ST_OUT    = 5'd16; // event word waiting
	localparam logic [4:0] ST_TCLR   = 5'd17; // clear_tables sweep
	localparam logic [4:0] ST_FIN    = 5'd18;

	logic [4:0] state_q, ret_q;

	// command word
	logic [2:0]  cmd_q;
	logic [6:0]  note_q, vel_q, link_q;
	logic [15:0] dur_q, tv_q;
	logic [31:0] now_q, tend_q;
	logic        purge2_q;   // second purge (own note) under way
	logic        pend_q;     // an event is held back to learn last
	event_t      pend_ev_q;
	event_t      out_q;

	logic [6:0]  def_vel_q;
	logic [15:0] def_dur_q;

	logic [QW-1:0] head_q, tail_q, ptr_q, here_q;
	logic [CW-1:0] clr_q;
	logic [QUEUE_DEPTH-1:0] valid_q;

	// queue ram port: note and time
	logic          q_we;
	logic [QW-1:0] q_addr;
	logic [6:0]    qn_wd, qn_rd;
	logic [31:0]   qt_wd, qt_rd;

	// table ram port
	logic          t_we;
	logic [NW-1:0] t_addr;
	logic [6:0]    tvl_wd, tvl_rd, tlk_wd, tlk_rd;
	logic [15:0]   tdr_wd, tdr_rd;
	logic          tvl_we, tdr_we, tlk_we;

	nos_ram #(.WIDTH(7), .DEPTH(QUEUE_DEPTH)) u_qnote (
		.clk(clk), .we(q_we), .addr(q_addr), .wdata(qn_wd), .rdata(qn_rd));
	nos_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_qtime (
		.clk(clk), .we(q_we), .addr(q_addr), .wdata(qt_wd), .rdata(qt_rd));
	nos_ram #(.WIDTH(7), .DEPTH(NOTE_COUNT)) u_tvel (
		.clk(clk), .we(tvl_we), .addr(t_addr), .wdata(tvl_wd), .rdata(tvl_rd));
	nos_ram #(.WIDTH(16), .DEPTH(NOTE_COUNT)) u_tdur (
		.clk(clk), .we(tdr_we), .addr(t_addr), .wdata(tdr_wd), .rdata(tdr_rd));
	nos_ram #(.WIDTH(7), .DEPTH(NOTE_COUNT)) u_tlnk (
		.clk(clk), .we(tlk_we), .addr(t_addr), .wdata(tlk_wd), .rdata(tlk_rd));

	function automatic logic [QW-1:0] qnext(input logic [QW-1:0] i);
		return (i == QLAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [QW-1:0] qprev(input logic [QW-1:0] i);
		return (i == '0) ? QLAST : i - 1'b1;
	endfunction

	logic note_ok;
	assign note_ok = ({1'b0, note_q} < 8'(NOTE_COUNT));

	// ram port drive from state
	always_comb begin
		q_we   = 1'b0;
		q_addr = ptr_q;
		qn_wd  = '0;
		qt_wd  = '0;
		t_we   = 1'b0;
		t_addr = NW'(note_q);
		tvl_wd = '0;
		tdr_wd = '0;
		tlk_wd = '0;
		tvl_we = 1'b0;
		tdr_we = 1'b0;
		tlk_we = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				q_addr = clr_q[QW-1:0];
				q_we   = ({1'b0, clr_q} < (CW+1)'(QUEUE_DEPTH));
				qn_wd  = '0;
				qt_wd  = '0;
				t_addr = clr_q[NW-1:0];
				t_we   = ({1'b0, clr_q} < (CW+1)'(NOTE_COUNT));
			end
			ST_TCLR: begin
				t_addr = clr_q[NW-1:0];
				t_we   = 1'b1;
			end
			ST_TRD: begin
				if (note_ok) begin
					if (cmd_q == CMD_SET_VEL) begin
						tvl_we = 1'b1;
						tvl_wd = (tv_q > 16'd127) ? VEL_MAX : tv_q[6:0];
					end
					if (cmd_q == CMD_SET_DUR) begin
						tdr_we = 1'b1;
						tdr_wd = tv_q;
					end
					if (cmd_q == CMD_SET_LINK && note_q != '0 && tv_q <= 16'd127) begin
						tlk_we = 1'b1;
						tlk_wd = tv_q[6:0];
					end
				end
			end
			ST_FCHK: begin
				q_we  = 1'b1;   // popped slot time reset to zero
				qn_wd = qn_rd;
				qt_wd = '0;
			end
			// source slot data is back; write it one place up
			ST_MWR: begin
				q_addr = qnext(ptr_q);
				q_we   = 1'b1;
				qn_wd  = qn_rd;
				qt_wd  = qt_rd;
			end
			ST_PUT: begin
				q_addr = here_q;
				q_we   = 1'b1;
				qn_wd  = note_q;
				qt_wd  = tend_q;
			end
			default: ;
		endcase
		if (t_we) begin
			tvl_we = 1'b1;
			tdr_we = 1'b1;
			tlk_we = 1'b1;
		end
	end

	logic [6:0]  vel_res;
	logic [15:0] dur_res;
	assign vel_res = (vel_q != '0) ? vel_q : (tvl_rd != '0) ? tvl_rd : def_vel_q;
	assign dur_res = (dur_q != '0) ? dur_q : (tdr_rd != '0) ? tdr_rd : def_dur_q;

	logic [6:0] purge_note;
	assign purge_note = purge2_q ? note_q : link_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {2'b00, out_q.velocity, out_q.note};
	assign m_axis_tlast  = out_q.last;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_vel_q <= DEF_VEL_RESET;
			def_dur_q <= DEF_DUR_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DEF_VEL) begin
				def_vel_q <= cfg_data[6:0];
			end else if (cfg_data != '0) begin
				def_dur_q <= cfg_data;
			end
		end
	end

	// sequencer and emit helper: an event is held back until the next one (or
	// the end) tells whether it carries last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			ret_q    <= ST_IDLE;
			clr_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			valid_q  <= '0;
			pend_q   <= 1'b0;
			purge2_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if ({1'b0, clr_q} == (CW+1)'(((QUEUE_DEPTH > NOTE_COUNT) ?
							QUEUE_DEPTH : NOTE_COUNT) - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q  <= s_axis_tdata[2:0];
						note_q <= s_axis_tdata[9:3];
						vel_q  <= s_axis_tdata[16:10];
						dur_q  <= s_axis_tdata[32:17];
						now_q  <= s_axis_tdata[64:33];
						tv_q   <= s_axis_tdata[80:65];
						pend_q <= 1'b0;
						clr_q  <= '0;
						case (s_axis_tdata[2:0])
							CMD_TICK: begin
								ptr_q   <= head_q;
								state_q <= (head_q != tail_q) ? ST_TKRD : ST_IDLE;
							end
							CMD_CLEAR_TAB: state_q <= ST_TCLR;
							CMD_NOTE_ON, CMD_MUTE, CMD_SET_VEL, CMD_SET_DUR,
							CMD_SET_LINK: state_q <= ST_TRD;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_TCLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q[NW-1:0] == NW'(NOTE_COUNT - 1)) state_q <= ST_IDLE;
				end
				ST_TRD: begin
					if (!note_ok || cmd_q == CMD_SET_VEL || cmd_q == CMD_SET_DUR ||
							cmd_q == CMD_SET_LINK) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_TGET;
					end
				end
				ST_TGET: begin
					vel_q    <= vel_res;
					link_q   <= tlk_rd;
					ptr_q    <= head_q;
					tend_q   <= now_q + {16'd0, dur_res};
					purge2_q <= (cmd_q == CMD_MUTE) || (tlk_rd == '0);
					state_q  <= ST_PRD;
				end
				ST_PRD: begin
					if (ptr_q == tail_q) begin
						if (!purge2_q) begin
							purge2_q <= 1'b1;
							ptr_q    <= head_q;
						end else begin
							state_q <= (cmd_q == CMD_MUTE) ? ST_FIN : ST_ON;
						end
					end else begin
						state_q <= ST_PCHK;
					end
				end
				ST_PCHK: begin
					if (valid_q[ptr_q] && qn_rd == purge_note) begin
						valid_q[ptr_q] <= 1'b0;
						pend_q         <= 1'b1;
						pend_ev_q      <= '{note: purge_note, velocity: 7'd0, last: 1'b0};
						if (pend_q) begin
							out_q   <= pend_ev_q;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_PRD;
						end
						if (!purge2_q) begin
							purge2_q <= 1'b1;
							ptr_q    <= head_q;
							ret_q    <= ST_PRD;
						end else begin
							ret_q <= (cmd_q == CMD_MUTE) ? ST_FIN : ST_ON;
							if (!pend_q) state_q <= (cmd_q == CMD_MUTE) ? ST_FIN : ST_ON;
						end
					end else begin
						ptr_q   <= qnext(ptr_q);
						state_q <= ST_PRD;
					end
				end
				ST_ON: begin
					pend_q    <= 1'b1;
					pend_ev_q <= '{note: note_q, velocity: vel_q, last: 1'b0};
					ptr_q     <= head_q;
					if (pend_q) begin
						out_q   <= pend_ev_q;
						state_q <= ST_OUT;
					end
					ret_q <= ST_FULL;
					if (!pend_q) state_q <= ST_FULL;
				end
				ST_FULL: begin
					if (qnext(tail_q) == head_q) begin
						ptr_q   <= head_q;
						state_q <= ST_FCHK;
					end else begin
						ptr_q   <= head_q;
						state_q <= ST_SRD;
					end
				end
				ST_FCHK: begin
					valid_q[head_q] <= 1'b0;
					head_q          <= qnext(head_q);
					ptr_q           <= qnext(head_q);
					ret_q           <= ST_SRD;
					state_q         <= ST_SRD;
					if (valid_q[head_q]) begin
						pend_q    <= 1'b1;
						pend_ev_q <= '{note: qn_rd, velocity: 7'd0, last: 1'b0};
						if (pend_q) begin
							out_q   <= pend_ev_q;
							state_q <= ST_OUT;
						end
					end
				end
				ST_SRD: begin
					if (ptr_q == tail_q) begin
						// goes at the tail, nothing to shift
						here_q  <= ptr_q;
						tail_q  <= qnext(tail_q);
						state_q <= ST_PUT;
					end else begin
						state_q <= ST_SCHK;
					end
				end
				ST_SCHK: begin
					if (qt_rd < tend_q) begin
						ptr_q   <= qnext(ptr_q);
						state_q <= ST_SRD;
					end else begin
						here_q  <= ptr_q;
						ptr_q   <= qprev(tail_q);
						tail_q  <= qnext(tail_q);
						clr_q   <= '0;
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					// ptr_q holds the source slot; destination is qnext
					if (qnext(ptr_q) == here_q) begin
						state_q <= ST_PUT;
					end else begin
						state_q <= ST_MWR;
					end
				end
				ST_MWR: begin
					valid_q[qnext(ptr_q)] <= valid_q[ptr_q];
					ptr_q                 <= qprev(ptr_q);
					state_q               <= ST_MRD;
				end
				ST_PUT: begin
					valid_q[here_q] <= 1'b1;
					state_q         <= ST_FIN;
				end
				ST_TKRD: state_q <= ST_TKCHK;
				ST_TKCHK: begin
					state_q <= ST_IDLE;
					if (qt_rd <= now_q) begin
						valid_q[head_q] <= 1'b0;
						head_q          <= qnext(head_q);
						state_q         <= ST_FIN;
						if (valid_q[head_q]) begin
							pend_q    <= 1'b1;
							pend_ev_q <= '{note: qn_rd, velocity: 7'd0, last: 1'b0};
						end
					end
				end
				ST_FIN: begin
					if (pend_q) begin
						out_q   <= '{note: pend_ev_q.note, velocity: pend_ev_q.velocity,
							last: 1'b1};
						pend_q  <= 1'b0;
						ret_q   <= ST_IDLE;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("output word pending while accepting commands");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("event word dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("held event lost at end of command");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("clearing pass restarted");

endmodule

`default_nettype wire

// ----- bench/note_off_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// note_off_scheduler_tb: self-checking bench for the note-off scheduler
// drives command words with bursty timing, predicts the emitted note events
// with a behavioral copy of the queue and tables, and checks every event word
// ----------------------------------------------------------------------------
module note_off_scheduler_tb;
	import nos_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH     = 128;
	localparam int NOTES      = 128;
	localparam int DRAIN_WAIT = 6 * QDEPTH + 64; // worst command time plus margin
	localparam int IDLE_LIMIT = 20000;           // cycles with no word moving
	localparam logic [2:0] CMD_BAD = 3'd7;       // unused selector

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	note_off_scheduler u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// predicted scheduler state
	// ------------------------------------------------------------------
	logic [6:0]  off_note [QDEPTH];
	logic [31:0] off_time [QDEPTH];
	bit          off_live [QDEPTH];
	int          head_idx;
	int          tail_idx;
	logic [6:0]  vel_tab  [NOTES];
	logic [15:0] dur_tab  [NOTES];
	logic [6:0]  link_tab [NOTES];
	logic [6:0]  dflt_vel;
	logic [15:0] dflt_dur;

	event_t      pending_events[$];   // note events still to come out
	int          fail_count;
	logic [31:0] clock_ms;            // running musical time for stimulus

	// sender shaping
	int burst_left;
	bit no_gaps;
	// receiver hold-off request, toggled by the test sequence
	bit hold_req;
	bit hold_seen;
	int hold_left;
	int rx_phase;

	function automatic int ring_next(int i);
		return (i + 1) % QDEPTH;
	endfunction

	function automatic void push_event(logic [6:0] n, logic [6:0] v);
		event_t e;
		e.note     = n;
		e.velocity = v;
		e.last     = 1'b0;
		pending_events.push_back(e);
	endfunction

	// cancel the first live queued instance of a note, sending its note-off
	function automatic void cancel_note(logic [6:0] n);
		int i;
		i = head_idx;
		while (i != tail_idx) begin
			if (off_live[i] && off_note[i] == n) begin
				off_live[i] = 0;
				push_event(n, 7'd0);
				return;
			end
			i = ring_next(i);
		end
	endfunction

	function automatic void pop_oldest();
		if (head_idx != tail_idx) begin
			if (off_live[head_idx])
				push_event(off_note[head_idx], 7'd0);
			off_live[head_idx] = 0;
			off_time[head_idx] = '0;
			head_idx = ring_next(head_idx);
		end
	endfunction

	// sorted insert: goes in front of the first entry with equal or later time
	function automatic void schedule_off(logic [6:0] n, logic [31:0] t);
		int slot;
		int i;
		int p;
		if (ring_next(tail_idx) == head_idx)
			pop_oldest();
		slot = head_idx;
		while (slot != tail_idx && off_time[slot] < t)
			slot = ring_next(slot);
		i = tail_idx;
		tail_idx = ring_next(tail_idx);
		while (i != slot) begin
			p = (i == 0) ? QDEPTH - 1 : i - 1;
			off_note[i] = off_note[p];
			off_time[i] = off_time[p];
			off_live[i] = off_live[p];
			i = p;
		end
		off_note[slot] = n;
		off_time[slot] = t;
		off_live[slot] = 1;
	endfunction

	function automatic void predict_events(logic [2:0] cmd, logic [6:0] n, logic [6:0] v,
		logic [15:0] d, logic [31:0] t, logic [15:0] tv);
		int first;
		first = pending_events.size();
		case (cmd)
			CMD_TICK: begin
				if (head_idx != tail_idx && off_time[head_idx] <= t)
					pop_oldest();
			end
			CMD_CLEAR_TAB: begin
				for (int k = 0; k < NOTES; k++) begin
					vel_tab[k]  = '0;
					dur_tab[k]  = '0;
					link_tab[k] = '0;
				end
			end
			CMD_NOTE_ON: begin
				if (v == 0) v = vel_tab[n];
				if (v == 0) v = dflt_vel;
				if (link_tab[n] != 0) cancel_note(link_tab[n]);
				cancel_note(n);
				push_event(n, v);
				if (d == 0) d = dur_tab[n];
				if (d == 0) d = dflt_dur;
				schedule_off(n, t + 32'(d));
			end
			CMD_MUTE: cancel_note(n);
			CMD_SET_VEL: vel_tab[n] = (tv > 127) ? VEL_MAX : tv[6:0];
			CMD_SET_DUR: dur_tab[n] = tv;
			CMD_SET_LINK: begin
				if (n != 0 && tv <= 127)
					link_tab[n] = tv[6:0];
			end
			default: ; // unused selector does nothing
		endcase
		if (pending_events.size() > first)
			pending_events[pending_events.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// sender: one command word, bursts separated by random gaps
	// ------------------------------------------------------------------
	task automatic send_cmd(logic [2:0] cmd, logic [6:0] n, logic [6:0] v,
		logic [15:0] d, logic [31:0] t, logic [15:0] tv);
		if (burst_left == 0) begin
			if (!no_gaps && $urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, tv, t, d, v, n, cmd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_events(cmd, n, v, d, t, tv);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_DEF_VEL)
			dflt_vel = val[6:0];
		else if (val != 0)
			dflt_dur = val;
	endtask

	// one random command, mostly note-ons and ticks on a moving clock
	task automatic send_random();
		int pick;
		logic [31:0] t;
		pick = $urandom_range(0, 99);
		clock_ms = clock_ms + $urandom_range(0, 400);
		t = ($urandom_range(0, 19) == 0) ? 32'($urandom) : clock_ms;
		if (pick < 45)
			send_cmd(CMD_NOTE_ON, 7'($urandom_range(30, 45)),
				($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom),
				($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 3000)),
				t, 16'($urandom));
		else if (pick < 48)
			send_cmd(CMD_NOTE_ON, 7'($urandom), 7'($urandom), 16'($urandom),
				32'($urandom), 16'($urandom));
		else if (pick < 75)
			send_cmd(CMD_TICK, 7'($urandom), 7'($urandom), 16'($urandom), t,
				16'($urandom));
		else if (pick < 82)
			send_cmd(CMD_MUTE, 7'($urandom_range(30, 45)), 7'($urandom),
				16'($urandom), t, 16'($urandom));
		else if (pick < 86)
			send_cmd(CMD_SET_VEL, 7'($urandom_range(30, 45)), 7'($urandom),
				16'($urandom), t, ($urandom_range(0, 1)) ? 16'($urandom_range(0, 127))
				: 16'($urandom));
		else if (pick < 90)
			send_cmd(CMD_SET_DUR, 7'($urandom_range(30, 45)), 7'($urandom),
				16'($urandom), t, 16'($urandom_range(0, 2000)));
		else if (pick < 96)
			send_cmd(CMD_SET_LINK, 7'($urandom_range(30, 45)), 7'($urandom),
				16'($urandom), t, ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 45)));
		else if (pick < 98)
			send_cmd(CMD_CLEAR_TAB, 7'($urandom), 7'($urandom), 16'($urandom), t,
				16'($urandom));
		else
			send_cmd(CMD_BAD, 7'($urandom), 7'($urandom), 16'($urandom), t,
				16'($urandom));
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	task automatic test_directed();
		// tick on an empty queue, then plain defaults
		send_cmd(CMD_TICK, 7'd0, 7'd0, 16'd0, 32'hFFFF_FFFF, 16'd0);
		send_cmd(CMD_NOTE_ON, 7'd0, 7'd0, 16'd0, 32'd0, 16'd0);
		send_cmd(CMD_NOTE_ON, 7'd127, 7'd127, 16'hFFFF, 32'd10, 16'hFFFF);
		// same note again purges its queued instance
		send_cmd(CMD_NOTE_ON, 7'd0, 7'd1, 16'd5, 32'd20, 16'd0);
		// tick before and after expiry
		send_cmd(CMD_TICK, 7'd0, 7'd0, 16'd0, 32'd24, 16'd0);
		send_cmd(CMD_TICK, 7'd0, 7'd0, 16'd0, 32'd25, 16'd0);
		// table writes, saturation and ignored links
		send_cmd(CMD_SET_VEL, 7'd5, 7'd0, 16'd0, 32'd0, 16'd200);
		send_cmd(CMD_SET_VEL, 7'd6, 7'd0, 16'd0, 32'd0, 16'd127);
		send_cmd(CMD_SET_DUR, 7'd5, 7'd0, 16'd0, 32'd0, 16'd7);
		send_cmd(CMD_SET_LINK, 7'd5, 7'd0, 16'd0, 32'd0, 16'd6);
		send_cmd(CMD_SET_LINK, 7'd6, 7'd0, 16'd0, 32'd0, 16'd128);
		send_cmd(CMD_SET_LINK, 7'd0, 7'd0, 16'd0, 32'd0, 16'd5);
		// linked note-off, own note-off, note-on
		send_cmd(CMD_NOTE_ON, 7'd6, 7'd0, 16'd0, 32'd100, 16'd0);
		send_cmd(CMD_NOTE_ON, 7'd5, 7'd0, 16'd0, 32'd101, 16'd0);
		send_cmd(CMD_NOTE_ON, 7'd5, 7'd0, 16'd0, 32'd102, 16'd0);
		// mute, then pop of the cancelled slot gives nothing
		send_cmd(CMD_MUTE, 7'd5, 7'd0, 16'd0, 32'd0, 16'd0);
		send_cmd(CMD_MUTE, 7'd99, 7'd0, 16'd0, 32'd0, 16'd0);
		send_cmd(CMD_SET_LINK, 7'd5, 7'd0, 16'd0, 32'd0, 16'd0);
		// end time wraps past 2^32
		send_cmd(CMD_NOTE_ON, 7'd9, 7'd3, 16'hFFFF, 32'hFFFF_FFF0, 16'd0);
		send_cmd(CMD_CLEAR_TAB, 7'd0, 7'd0, 16'd0, 32'd0, 16'd0);
		send_cmd(CMD_BAD, 7'h7F, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		repeat (6) send_cmd(CMD_TICK, 7'd0, 7'd0, 16'd0, 32'hFFFF_FFFF, 16'd0);
	endtask

	task automatic test_registers();
		logic [15:0] vals [5];
		vals = '{16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd300};
		for (int k = 0; k < 5; k++) begin
			write_reg(CFG_DEF_VEL, (k == 2) ? 16'h007F : 16'($urandom_range(0, 127)));
			write_reg(CFG_DEF_DUR, vals[k]);
			for (int j = 0; j < 20; j++) send_random();
		end
		write_reg(CFG_DEF_VEL, 16'd0);
		for (int j = 0; j < 10; j++) send_random();
		write_reg(CFG_DEF_VEL, 16'd64);
		write_reg(CFG_DEF_DUR, 16'd1000);
	endtask

	// more note-ons than the queue holds, so the head entries (earliest end time) get forced out
	task automatic test_queue_full();
		for (int k = 0; k < 135; k++) begin
			clock_ms = clock_ms + 1;
			send_cmd(CMD_NOTE_ON, 7'(k), 7'd0, 16'($urandom_range(1, 60000)),
				clock_ms, 16'd0);
		end
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_backpressure();
		wait_idle();
		no_gaps  = 1;
		hold_req = ~hold_req;
		for (int k = 0; k < 30; k++)
			send_cmd(CMD_NOTE_ON, 7'($urandom_range(50, 60)), 7'($urandom), 16'd0,
				clock_ms, 16'd0);
		no_gaps = 0;
	endtask

	task automatic test_random_mix();
		for (int k = 0; k < 60; k++) send_random();
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = 1'b0;
		cfg_data      = '0;
		fail_count    = 0;
		burst_left    = 0;
		no_gaps       = 0;
		hold_req      = 0;
		clock_ms      = 32'd1000;
		head_idx      = 0;
		tail_idx      = 0;
		dflt_vel      = DEF_VEL_RESET;
		dflt_dur      = DEF_DUR_RESET;
		for (int k = 0; k < QDEPTH; k++) begin
			off_note[k] = '0;
			off_time[k] = '0;
			off_live[k] = 0;
		end
		for (int k = 0; k < NOTES; k++) begin
			vel_tab[k]  = '0;
			dur_tab[k]  = '0;
			link_tab[k] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_registers();
		test_queue_full();
		test_backpressure();
		test_random_mix();

		wait_idle();
		if (fail_count == 0)
			$display("note_off_scheduler_tb: clean");
		else
			$display("note_off_scheduler_tb: errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver: rotating stall pattern, plus a long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		m_axis_tready = 1'b0;
		hold_seen     = 0;
		hold_left     = 0;
		rx_phase      = 0;
	end

	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (hold_req != hold_seen) begin
			hold_seen     <= hold_req;
			hold_left     <= 600;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			case ((rx_phase / 96) % 3)
				0:       m_axis_tready <= 1'b1;                      // free running
				1:       m_axis_tready <= 1'($urandom_range(0, 1));  // random stalls
				default: m_axis_tready <= (rx_phase % 4 == 0);       // slow sink
			endcase
		end
	end

	// ------------------------------------------------------------------
	// checker: every event word against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		event_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected event word note=%0d velocity=%0d",
					m_axis_tdata[6:0], m_axis_tdata[13:7]);
				fail_count++;
			end else begin
				want = pending_events.pop_front();
				if (m_axis_tdata[6:0] !== want.note) begin
					$error("out_note expected %0d got %0d", want.note, m_axis_tdata[6:0]);
					fail_count++;
				end
				if (m_axis_tdata[13:7] !== want.velocity) begin
					$error("out_velocity expected %0d got %0d", want.velocity,
						m_axis_tdata[13:7]);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last expected %0d got %0d", want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long without any word moving ends the run
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("note_off_scheduler_tb: errors");
			$finish;
		end
	end

endmodule

// ----- files.f -----
hw/rtl/nos_pkg.sv
hw/rtl/nos_ram.sv
hw/rtl/note_off_scheduler.sv
bench/note_off_scheduler_tb.sv
